// File: design/qbss_pkg.sv
// shared types and character codes for the statement splitter
package qbss_pkg;

    // characters that steer the splitter
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_LSQ    = 8'h5B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;
    localparam logic [7:0] CH_RSQ    = 8'h5D;

    // width of the nest depth reported with each result
    localparam int DEPTH_W = 5;

    // byte class worked out by the front end
    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_SEMI,
        CLS_QUOTE,
        CLS_OPEN_CURLY,
        CLS_OPEN_SQ,
        CLS_CLOSE_CURLY,
        CLS_CLOSE_SQ
    } t_cls;

    // verdict codes on the result channel
    typedef enum logic [2:0] {
        VERDICT_CHAR      = 3'd0,
        VERDICT_END       = 3'd1,
        VERDICT_SEMIBRACE = 3'd2,
        VERDICT_MISMATCH  = 3'd3,
        VERDICT_IGNORED   = 3'd4,
        VERDICT_OVERFLOW  = 3'd5
    } t_verdict;

    // classified request held in the queue
    typedef struct packed {
        logic [7:0] text_byte;
        logic       doc_start;
        t_cls       cls;
        logic       is_bslash;
    } t_item;

    // map a byte to its class
    function automatic t_cls classify(input logic [7:0] b);
        t_cls c;
        unique case (b)
            CH_SEMI:   c = CLS_SEMI;
            CH_QUOTE:  c = CLS_QUOTE;
            CH_LCURLY: c = CLS_OPEN_CURLY;
            CH_LSQ:    c = CLS_OPEN_SQ;
            CH_RCURLY: c = CLS_CLOSE_CURLY;
            CH_RSQ:    c = CLS_CLOSE_SQ;
            default:   c = CLS_OTHER;
        endcase
        return c;
    endfunction

endpackage

// File: design/qbss_if.sv
// request and result channel interfaces of the statement splitter

// byte request channel
interface qbss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       doc_start;

    modport source (output valid, output text_byte, output doc_start, input ready);
    modport sink   (input valid, input text_byte, input doc_start, output ready);
endinterface

// result channel
interface qbss_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [2:0] verdict;
    logic [4:0] nest_depth;

    modport source (output valid, output byte_out, output verdict, output nest_depth,
                    input ready);
    modport sink   (input valid, input byte_out, input verdict, input nest_depth,
                    output ready);
endinterface

// File: design/qbss_front.sv
// front end: accepts byte requests and classifies them into a register stage
module qbss_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    qbss_in_if.sink          i_in,
    output logic             o_valid,
    output qbss_pkg::t_item  o_item,
    input  logic             i_ready
);

    logic            r_valid;
    qbss_pkg::t_item r_item;

    // stage takes a request when empty or when its content moves on
    assign i_in.ready = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // classified payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.text_byte <= i_in.text_byte;
            r_item.doc_start <= i_in.doc_start;
            r_item.cls       <= qbss_pkg::classify(i_in.text_byte);
            r_item.is_bslash <= (i_in.text_byte == qbss_pkg::CH_BSLASH);
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: design/qbss_queue.sv
// two-entry queue between front end and back end
module qbss_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  qbss_pkg::t_item  i_push_item,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output qbss_pkg::t_item  o_pop_item,
    input  logic             i_pop_ready
);

    qbss_pkg::t_item r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= !r_wr_ptr;
            if (w_pop)  r_rd_ptr <= !r_rd_ptr;
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// File: design/qbss_back.sv
// back end: quote and bracket state, verdict and output register
module qbss_back #(
    parameter int MAX_NESTING = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  qbss_pkg::t_item  i_item,
    output logic             o_ready,
    qbss_out_if.source       o_out
);

    localparam int LVL_W = $clog2(MAX_NESTING + 1);

    // splitter state
    logic                    r_in_quotes;
    logic                    r_prev_bslash;
    logic [LVL_W-1:0]        r_level;
    logic                    r_failed;
    logic [MAX_NESTING-1:0]  r_kinds;   // bit 0 is the top of stack, 1 for curly

    logic                    n_in_quotes;
    logic                    n_prev_bslash;
    logic [LVL_W-1:0]        n_level;
    logic                    n_failed;
    logic [MAX_NESTING-1:0]  n_kinds;
    qbss_pkg::t_verdict      n_verdict;

    // output register
    logic                    r_out_valid;
    logic [7:0]              r_byte;
    qbss_pkg::t_verdict      r_verdict;
    logic [4:0]              r_depth;

    logic                    w_take;
    logic                    w_quotes;
    logic                    w_top_curly;

    assign o_ready     = !r_out_valid || o_out.ready;
    assign w_take      = i_valid && o_ready;
    assign w_top_curly = r_kinds[0];

    // next state for one byte
    always_comb begin
        // document start clears everything but the stack contents
        n_in_quotes   = i_item.doc_start ? 1'b0 : r_in_quotes;
        n_prev_bslash = i_item.doc_start ? 1'b0 : r_prev_bslash;
        n_level       = i_item.doc_start ? '0 : r_level;
        n_failed      = i_item.doc_start ? 1'b0 : r_failed;
        n_kinds       = r_kinds;
        n_verdict     = qbss_pkg::VERDICT_CHAR;
        w_quotes      = n_in_quotes;

        priority if (n_failed) begin
            n_verdict = qbss_pkg::VERDICT_IGNORED;
        end else if (i_item.cls == qbss_pkg::CLS_SEMI && !n_in_quotes && n_level == '0) begin
            n_verdict     = qbss_pkg::VERDICT_END;
            n_prev_bslash = i_item.is_bslash;
        end else if (i_item.cls == qbss_pkg::CLS_SEMI && !n_in_quotes && w_top_curly) begin
            n_verdict     = qbss_pkg::VERDICT_SEMIBRACE;
            n_failed      = 1'b1;
            n_prev_bslash = i_item.is_bslash;
        end else begin
            // quote tracking, a backslash keeps the string open
            if (i_item.cls == qbss_pkg::CLS_QUOTE) begin
                if (!n_in_quotes)
                    w_quotes = 1'b1;
                else if (!n_prev_bslash)
                    w_quotes = 1'b0;
            end
            n_in_quotes = w_quotes;

            // bracket stack outside strings
            if (!w_quotes) begin
                unique case (i_item.cls)
                    qbss_pkg::CLS_OPEN_CURLY, qbss_pkg::CLS_OPEN_SQ: begin
                        if (n_level == LVL_W'(MAX_NESTING)) begin
                            n_failed  = 1'b1;
                            n_verdict = qbss_pkg::VERDICT_OVERFLOW;
                        end else begin
                            n_kinds    = r_kinds << 1;
                            n_kinds[0] = (i_item.cls == qbss_pkg::CLS_OPEN_CURLY);
                            n_level    = n_level + LVL_W'(1);
                        end
                    end
                    qbss_pkg::CLS_CLOSE_CURLY, qbss_pkg::CLS_CLOSE_SQ: begin
                        if (n_level != '0 &&
                            w_top_curly == (i_item.cls == qbss_pkg::CLS_CLOSE_CURLY)) begin
                            n_kinds = r_kinds >> 1;
                            n_level = n_level - LVL_W'(1);
                        end else begin
                            n_failed  = 1'b1;
                            n_verdict = qbss_pkg::VERDICT_MISMATCH;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            n_prev_bslash = i_item.is_bslash;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quotes   <= 1'b0;
            r_prev_bslash <= 1'b0;
            r_level       <= '0;
            r_failed      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_quotes   <= n_in_quotes;
                r_prev_bslash <= n_prev_bslash;
                r_level       <= n_level;
                r_failed      <= n_failed;
            end
            if (o_ready) r_out_valid <= i_valid;
        end
    end

    // stack contents and result payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_kinds   <= n_kinds;
            r_byte    <= i_item.text_byte;
            r_verdict <= n_verdict;
            r_depth   <= qbss_pkg::DEPTH_W'(n_level);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.byte_out   = r_byte;
    assign o_out.verdict    = r_verdict;
    assign o_out.nest_depth = r_depth;

endmodule

// File: design/quote_bracket_aware_statement_splitter_core.sv
// top level of the quote and bracket aware statement splitter
//
// Usage: text bytes arrive on i_in (text_byte, doc_start) one request per
// valid/ready handshake. Every byte gives exactly one result on o_out:
// the byte echoed, a verdict (statement char, statement end, semicolon in
// braces, bracket mismatch, ignored after error, stack overflow) and the
// number of open brackets after the byte. Assert doc_start with the first
// byte of each document to clear the quote, bracket and error state.
// Path: a byte accepted on i_in passes the front register, the two-entry
// queue and the result register before its result is offered on o_out.
// Throughput: one byte per clock sustained while o_out.ready stays high;
// the quote flag and the bracket stack (a shift register, top of stack at
// a fixed bit) update in the back end.
// Reset: synchronous on i_rst_n, empties all stages and clears the state.
// Stalls: when o_out.ready is low the result register holds, the queue fills
// and i_in.ready drops after the queue and the front register are full.
module quote_bracket_aware_statement_splitter_core #(
    parameter int MAX_NESTING = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qbss_in_if.sink     i_in,
    qbss_out_if.source  o_out
);

    logic            w_front_valid;
    qbss_pkg::t_item w_front_item;
    logic            w_front_ready;
    logic            w_q_valid;
    qbss_pkg::t_item w_q_item;
    logic            w_q_ready;

    // accept and classify
    qbss_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (w_front_valid),
        .o_item  (w_front_item),
        .i_ready (w_front_ready)
    );

    // decoupling queue
    qbss_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .i_push_item  (w_front_item),
        .o_push_ready (w_front_ready),
        .o_pop_valid  (w_q_valid),
        .o_pop_item   (w_q_item),
        .i_pop_ready  (w_q_ready)
    );

    // state update and result register
    qbss_back #(
        .MAX_NESTING (MAX_NESTING)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_item  (w_q_item),
        .o_ready (w_q_ready),
        .o_out   (o_out)
    );

    // reset empties the queue and the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid && !w_q_valid)
        else $error("pipeline not empty after reset");

    // a statement ends only with no bracket open
    a_end_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.verdict == qbss_pkg::VERDICT_END |-> o_out.nest_depth == 5'd0)
        else $error("statement end with brackets open");

    // overflow is reported only at full nesting
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.verdict == qbss_pkg::VERDICT_OVERFLOW
        |-> o_out.nest_depth == 5'(MAX_NESTING))
        else $error("overflow below full nesting");

endmodule

// File: dv/quote_bracket_aware_statement_splitter_core_tb.sv
// self-checking testbench for the quote and bracket aware statement splitter
`timescale 1ns / 100ps

module quote_bracket_aware_statement_splitter_core_tb;

    localparam int MAX_NESTING    = 16;
    localparam int KIND_W         = $clog2(MAX_NESTING);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_BYTES   = 1410;
    localparam int N_DIRECTED     = 25;

    // one result of the splitter
    typedef struct {
        logic [7:0]          ch;
        qbss_pkg::t_verdict  verdict;
        logic [4:0]          depth;
    } t_split;

    // one row of the directed stimulus table
    typedef struct {
        logic [7:0]          ch;
        logic                doc;
        int                  reps;
        bit                  typed;
        qbss_pkg::t_verdict  verdict;
        logic [4:0]          depth;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    qbss_in_if  byte_ch ();
    qbss_out_if split_ch ();

    quote_bracket_aware_statement_splitter_core #(
        .MAX_NESTING(MAX_NESTING)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (byte_ch),
        .o_out  (split_ch)
    );

    // splitter state as predicted
    bit         in_string;
    logic [7:0] last_ch;
    bit         kinds [MAX_NESTING];
    int         open_level;
    bit         err_seen;
    bit         deep_doc;

    t_split     pending_splits [$];
    t_split     head_split;
    int         mismatches;
    int         sender_idle_pct;
    int         receiver_stall_pct;
    int         quiet_cycles;

    logic [7:0] steer_chars [7] = '{qbss_pkg::CH_SEMI, qbss_pkg::CH_QUOTE,
                                    qbss_pkg::CH_BSLASH, qbss_pkg::CH_LCURLY,
                                    qbss_pkg::CH_LSQ, qbss_pkg::CH_RCURLY,
                                    qbss_pkg::CH_RSQ};

    // directed requests: extremes, quoting, escapes, nesting and every error
    t_row directed_rows [N_DIRECTED] = '{
        '{8'h00,               1'b1, 1,  1'b1, qbss_pkg::VERDICT_CHAR,      5'd0},
        '{8'hFF,               1'b0, 1,  1'b1, qbss_pkg::VERDICT_CHAR,      5'd0},
        '{qbss_pkg::CH_SEMI,   1'b0, 1,  1'b1, qbss_pkg::VERDICT_END,       5'd0},
        '{qbss_pkg::CH_LCURLY, 1'b0, 1,  1'b0, qbss_pkg::VERDICT_CHAR,      5'd0},
        '{qbss_pkg::CH_LSQ,    1'b0, 1,  1'b0, qbss_pkg::VERDICT_CHAR,      5'd0},
        '{qbss_pkg::CH_SEMI,   1'b0, 1,  1'b0, qbss_pkg::VERDICT_CHAR,      5'd0},
        '{qbss_pkg::CH_QUOTE,  1'b0, 1,  1'b0, qbss_pkg::VERDICT_CHAR,      5'd0},
        '{qbss_pkg::CH_BSLASH, 1'b0, 1,  1'b0, qbss_pkg::VERDICT_CHAR,      5'd0},
        '{qbss_pkg::CH_QUOTE,  1'b0, 1,  1'b0, qbss_pkg::VERDICT_CHAR,      5'd0},
        '{qbss_pkg::CH_SEMI,   1'b0, 1,  1'b0, qbss_pkg::VERDICT_CHAR,      5'd0},
        '{qbss_pkg::CH_RCURLY, 1'b0, 1,  1'b0, qbss_pkg::VERDICT_CHAR,      5'd0},
        '{qbss_pkg::CH_QUOTE,  1'b0, 1,  1'b0, qbss_pkg::VERDICT_CHAR,      5'd0},
        '{qbss_pkg::CH_RSQ,    1'b0, 1,  1'b0, qbss_pkg::VERDICT_CHAR,      5'd0},
        '{qbss_pkg::CH_SEMI,   1'b0, 1,  1'b1, qbss_pkg::VERDICT_SEMIBRACE, 5'd1},
        '{8'h41,               1'b0, 1,  1'b1, qbss_pkg::VERDICT_IGNORED,   5'd1},
        '{qbss_pkg::CH_RSQ,    1'b1, 1,  1'b1, qbss_pkg::VERDICT_MISMATCH,  5'd0},
        '{qbss_pkg::CH_LSQ,    1'b1, 1,  1'b0, qbss_pkg::VERDICT_CHAR,      5'd0},
        '{qbss_pkg::CH_RCURLY, 1'b0, 1,  1'b1, qbss_pkg::VERDICT_MISMATCH,  5'd1},
        '{qbss_pkg::CH_LCURLY, 1'b1, 1,  1'b0, qbss_pkg::VERDICT_CHAR,      5'd0},
        '{qbss_pkg::CH_LSQ,    1'b0, 15, 1'b0, qbss_pkg::VERDICT_CHAR,      5'd0},
        '{qbss_pkg::CH_LCURLY, 1'b0, 1,  1'b1, qbss_pkg::VERDICT_OVERFLOW,  5'd16},
        '{qbss_pkg::CH_RCURLY, 1'b1, 1,  1'b1, qbss_pkg::VERDICT_MISMATCH,  5'd0},
        '{qbss_pkg::CH_LCURLY, 1'b1, 1,  1'b0, qbss_pkg::VERDICT_CHAR,      5'd0},
        '{qbss_pkg::CH_RCURLY, 1'b0, 1,  1'b0, qbss_pkg::VERDICT_CHAR,      5'd0},
        '{qbss_pkg::CH_SEMI,   1'b0, 1,  1'b1, qbss_pkg::VERDICT_END,       5'd0}
    };

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // work out the verdict of one byte and advance the predicted state
    function automatic qbss_pkg::t_verdict split_byte(input logic [7:0] ch, input logic doc);
        qbss_pkg::t_verdict v;
        bit                 want_curly;
        v = qbss_pkg::VERDICT_CHAR;
        if (doc) begin
            in_string  = 1'b0;
            last_ch    = 8'h00;
            open_level = 0;
            err_seen   = 1'b0;
        end
        if (err_seen) return qbss_pkg::VERDICT_IGNORED;
        if (ch == qbss_pkg::CH_SEMI && !in_string && open_level == 0) begin
            v = qbss_pkg::VERDICT_END;
        end else if (ch == qbss_pkg::CH_SEMI && !in_string
                     && kinds[KIND_W'(open_level - 1)]) begin
            err_seen = 1'b1;
            v = qbss_pkg::VERDICT_SEMIBRACE;
        end else begin
            // quote flag, an escaped quote keeps the string open
            if (ch == qbss_pkg::CH_QUOTE) begin
                if (!in_string)
                    in_string = 1'b1;
                else if (last_ch != qbss_pkg::CH_BSLASH)
                    in_string = 1'b0;
            end
            // bracket stack outside strings
            if (!in_string) begin
                if (ch == qbss_pkg::CH_LCURLY || ch == qbss_pkg::CH_LSQ) begin
                    if (open_level >= MAX_NESTING) begin
                        err_seen = 1'b1;
                        v = qbss_pkg::VERDICT_OVERFLOW;
                    end else begin
                        kinds[KIND_W'(open_level)] = (ch == qbss_pkg::CH_LCURLY);
                        open_level++;
                    end
                end else if (ch == qbss_pkg::CH_RCURLY || ch == qbss_pkg::CH_RSQ) begin
                    want_curly = (ch == qbss_pkg::CH_RCURLY);
                    if (open_level > 0 && kinds[KIND_W'(open_level - 1)] == want_curly) begin
                        open_level--;
                    end else begin
                        err_seen = 1'b1;
                        v = qbss_pkg::VERDICT_MISMATCH;
                    end
                end
            end
        end
        last_ch = ch;
        return v;
    endfunction

    // present one request, with random idle cycles ahead of it
    task automatic offer(input logic [7:0] ch, input logic doc, input t_split result);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            byte_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid     = 1'b1;
        byte_ch.text_byte = ch;
        byte_ch.doc_start = doc;
        do @(posedge i_clk); while (!byte_ch.ready);
        pending_splits = {pending_splits, result};
        @(negedge i_clk);
    endtask

    // hold off until every expected result has arrived
    task automatic drain();
        byte_ch.valid = 1'b0;
        while (pending_splits.size() != 0) @(negedge i_clk);
    endtask

    // result side back-pressure
    initial begin
        split_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            split_ch.ready = ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && split_ch.valid && split_ch.ready) begin
            if (pending_splits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: byte %02h verdict %0d depth %0d",
                             split_ch.byte_out, split_ch.verdict, split_ch.nest_depth);
            end else begin
                head_split = pending_splits.pop_front();
                if (split_ch.byte_out !== head_split.ch
                        || split_ch.verdict !== head_split.verdict
                        || split_ch.nest_depth !== head_split.depth) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: got byte %02h verdict %0d depth %0d, %s %02h %0d %0d",
                                 split_ch.byte_out, split_ch.verdict, split_ch.nest_depth,
                                 "expected", head_split.ch, head_split.verdict,
                                 head_split.depth);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((byte_ch.valid && byte_ch.ready) || (split_ch.valid && split_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // stimulus
    initial begin
        t_split     result;
        logic [7:0] ch;
        logic       doc;
        int         counted;
        int         r;
        int         open_w;
        int         close_w;
        int         lvl_now;
        bit         str_now;

        byte_ch.valid      = 1'b0;
        byte_ch.text_byte  = 8'h00;
        byte_ch.doc_start  = 1'b0;
        i_rst_n            = 1'b0;
        mismatches         = 0;
        in_string          = 1'b0;
        last_ch            = 8'h00;
        open_level         = 0;
        err_seen           = 1'b0;
        deep_doc           = 1'b0;
        sender_idle_pct    = 9;
        receiver_stall_pct = 66;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table, typed expectations where obvious
        foreach (directed_rows[i]) begin
            for (int k = 0; k < directed_rows[i].reps; k++) begin
                doc = (k == 0) ? directed_rows[i].doc : 1'b0;
                result.ch      = directed_rows[i].ch;
                result.verdict = split_byte(directed_rows[i].ch, doc);
                result.depth   = open_level[4:0];
                if (directed_rows[i].typed) begin
                    result.verdict = directed_rows[i].verdict;
                    result.depth   = directed_rows[i].depth;
                end
                offer(directed_rows[i].ch, doc, result);
            end
        end
        drain();

        // random documents over three idle profiles
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct    = (phase == 0) ? 9  : (phase == 1) ? 66 : 0;
            receiver_stall_pct = (phase == 0) ? 66 : (phase == 1) ? 9  : 0;
            counted = 0;
            while (counted < RANDOM_BYTES / 3) begin
                // start a new document mostly after an error
                doc = 1'b0;
                if (err_seen)
                    doc = ($urandom_range(0, 9) != 0);
                else if ($urandom_range(0, 99) == 0)
                    doc = 1'b1;
                if (doc)
                    deep_doc = ($urandom_range(0, 7) == 0);
                lvl_now = doc ? 0 : open_level;
                str_now = doc ? 1'b0 : in_string;

                // mostly well-formed text, deep documents push towards overflow
                open_w  = deep_doc ? 45 : 15;
                close_w = deep_doc ? 5 : 15;
                r = $urandom_range(0, 99);
                if (r < open_w) begin
                    ch = $urandom_range(0, 1) ? qbss_pkg::CH_LCURLY : qbss_pkg::CH_LSQ;
                end else if (r < open_w + close_w) begin
                    if (lvl_now > 0 && !str_now)
                        ch = kinds[KIND_W'(lvl_now - 1)] ? qbss_pkg::CH_RCURLY
                                                         : qbss_pkg::CH_RSQ;
                    else
                        ch = 8'h61 + 8'($urandom_range(0, 25));
                end else if (r < open_w + close_w + 10) begin
                    ch = qbss_pkg::CH_QUOTE;
                end else if (r < open_w + close_w + 14) begin
                    ch = qbss_pkg::CH_BSLASH;
                end else if (r < open_w + close_w + 24) begin
                    if (!str_now && lvl_now > 0 && kinds[KIND_W'(lvl_now - 1)])
                        ch = 8'h61 + 8'($urandom_range(0, 25));
                    else
                        ch = qbss_pkg::CH_SEMI;
                end else if (r < open_w + close_w + 28) begin
                    ch = steer_chars[3'($urandom_range(0, 6))];
                end else begin
                    ch = 8'($urandom_range(0, 255));
                end

                result.ch      = ch;
                result.verdict = split_byte(ch, doc);
                result.depth   = open_level[4:0];
                if (result.verdict != qbss_pkg::VERDICT_IGNORED)
                    counted++;
                offer(ch, doc, result);
            end
            drain();
        end

        // let any stray result show up
        receiver_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
design/qbss_pkg.sv
design/qbss_if.sv
design/qbss_front.sv
design/qbss_queue.sv
design/qbss_back.sv
design/quote_bracket_aware_statement_splitter_core.sv
dv/quote_bracket_aware_statement_splitter_core_tb.sv
